@@ rtl/core/wmed_pkg.sv @@
package wmed_pkg;

  localparam int AXIS_W  = 16;
  localparam int DELTA_W = 16;
  localparam int TOTAL_W = 18;
  localparam int SUM_W   = 20;
  localparam int COUNT_W = 5;
  localparam int NOISE_W = 18;
  localparam int SLOT_W  = 3;
  localparam int MASK_W  = 8;
  localparam int FUNC_W  = 2;

  // Stream payload widths, padded to whole bytes
  localparam int S_DATA_W = 120;
  localparam int M_DATA_W = 80;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_SET    = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_CMP,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] z;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] x;
  } sample_t;

  typedef struct packed {
    logic [DELTA_W-1:0] dz;
    logic [DELTA_W-1:0] dy;
    logic [DELTA_W-1:0] dx;
  } delta_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   dz;
    logic [SUM_W-1:0]   dy;
    logic [SUM_W-1:0]   dx;
  } event_t;

endpackage

@@ rtl/core/wmed_abs_delta.sv @@
module wmed_abs_delta
  import wmed_pkg::*;
(
  input  sample_t cur,
  input  sample_t prev,
  output delta_t  delta
);

  logic signed [AXIS_W:0] diff_x, diff_y, diff_z;
  logic signed [AXIS_W:0] mag_x, mag_y, mag_z;

  always_comb begin
    diff_x = (AXIS_W+1)'(cur.x) - (AXIS_W+1)'(prev.x);
    diff_y = (AXIS_W+1)'(cur.y) - (AXIS_W+1)'(prev.y);
    diff_z = (AXIS_W+1)'(cur.z) - (AXIS_W+1)'(prev.z);
    mag_x  = diff_x[AXIS_W] ? -diff_x : diff_x;
    mag_y  = diff_y[AXIS_W] ? -diff_y : diff_y;
    mag_z  = diff_z[AXIS_W] ? -diff_z : diff_z;
    // Magnitude never exceeds 65535, so the low bits are exact
    delta.dx = mag_x[DELTA_W-1:0];
    delta.dy = mag_y[DELTA_W-1:0];
    delta.dz = mag_z[DELTA_W-1:0];
  end

endmodule

@@ rtl/core/windowed_motion_event_detector.sv @@
// Channel  Dir  Handshake           Payload
// s_*      in   s_tvalid/s_tready   s_tuser: func; s_tdata: sample, slot, baseline
// m_*      out  m_tvalid/m_tready   m_tuser: evaluated; m_tdata: mask, sums, count
// cfg_*    in   cfg_valid/cfg_ready cfg_data: noise_level (always ready)
//
// Operation: a sample with a full window walks the delta ring, one read per
//   entry, then the slot table, one read per slot, each through the single
//   read port of its memory, before it reaches the result register. Every
//   other request goes from accept straight to the final state and loads the
//   result register there; s_tready rises the cycle after a load.
// One request is in flight at a time; the result register holds a finished
//   result while the next request is accepted and worked on.
// Reset (rst, synchronous): clears history, ring fill state, slot valid bits,
//   noise level and the result valid bit; memories are not cleared.
// Stalls: if the result register is still occupied when a request finishes,
//   the block holds in its final state until m_tready frees it.
module windowed_motion_event_detector
  import wmed_pkg::*;
#(
  parameter int WINDOW_LEN  = 16,
  parameter int EVENT_SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z, [50:48] slot,
  // [70:51] base_dx, [90:71] base_dy, [110:91] base_dz, [115:111] base_count
  input  logic [S_DATA_W-1:0] s_tdata,
  // [1:0] func
  input  logic [FUNC_W-1:0]   s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [7:0] trigger_mask, [27:8] sum_dx, [47:28] sum_dy, [67:48] sum_dz,
  // [72:68] noisy_count
  output logic [M_DATA_W-1:0] m_tdata,
  // [0] evaluated
  output logic                m_tuser,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [NOISE_W-1:0]  cfg_data
);

  localparam int RW   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SW   = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int MAXV = (WINDOW_LEN > EVENT_SLOTS) ? WINDOW_LEN : EVENT_SLOTS;
  localparam int IW   = $clog2(MAXV + 1);

  // Unpack the request
  func_t               in_func;
  sample_t             in_sample;
  logic [SLOT_W-1:0]   in_slot;
  event_t              in_base;
  logic [COUNT_W-1:0]  in_count;

  always_comb begin
    in_func      = func_t'(s_tuser);
    in_sample.x  = s_tdata[15:0];
    in_sample.y  = s_tdata[31:16];
    in_sample.z  = s_tdata[47:32];
    in_slot      = s_tdata[50:48];
    in_count     = s_tdata[115:111];
    in_base.dx   = s_tdata[70:51];
    in_base.dy   = s_tdata[90:71];
    in_base.dz   = s_tdata[110:91];
    // Cap the baseline count at the window length
    in_base.count = (in_count > COUNT_W'(WINDOW_LEN)) ? COUNT_W'(WINDOW_LEN) : in_count;
  end

  // Architectural state
  state_t                 state, state_next;
  logic [NOISE_W-1:0]     noise_level;
  sample_t                prev_sample;
  logic                   have_prev;
  logic [RW-1:0]          wr_idx;
  logic                   ring_full;
  logic [EVENT_SLOTS-1:0] ev_valid;

  // Walk and result registers
  logic [IW-1:0]          cnt;
  logic [IW-1:0]          cnt_m1;
  logic [MASK_W-1:0]      res_mask;
  logic [SUM_W-1:0]       res_dx, res_dy, res_dz;
  logic [COUNT_W-1:0]     res_count;
  logic                   res_eval;

  logic                   out_valid;
  logic [MASK_W-1:0]      out_mask;
  logic [SUM_W-1:0]       out_dx, out_dy, out_dz;
  logic [COUNT_W-1:0]     out_count;
  logic                   out_eval;

  // Memories
  delta_t                 ring_mem [WINDOW_LEN];
  delta_t                 ring_rdata;
  event_t                 ev_mem [EVENT_SLOTS];
  event_t                 ev_rdata;

  delta_t                 new_delta;
  logic                   accept;
  logic                   slot_ok;
  logic                   fill_done;
  logic                   load_out;
  logic                   sum_last, cmp_last;
  logic [TOTAL_W-1:0]     entry_total;
  logic                   entry_noisy;
  logic                   slot_hit;

  wmed_abs_delta u_delta (
    .cur   (in_sample),
    .prev  (prev_sample),
    .delta (new_delta)
  );

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign slot_ok   = ({1'b0, in_slot} < (SLOT_W+1)'(EVENT_SLOTS));
  assign fill_done = ring_full || (wr_idx == RW'(WINDOW_LEN - 1));
  assign sum_last  = (cnt == IW'(WINDOW_LEN));
  assign cmp_last  = (cnt == IW'(EVENT_SLOTS));
  assign cnt_m1    = cnt - 1'b1;

  // Entry qualification against the noise level
  assign entry_total = TOTAL_W'(ring_rdata.dx) + TOTAL_W'(ring_rdata.dy)
                     + TOTAL_W'(ring_rdata.dz);
  assign entry_noisy = (entry_total > noise_level);

  // Slot compare: strict greater-than on all four values
  assign slot_hit = ev_valid[cnt_m1[SW-1:0]] &&
                    (res_dx > ev_rdata.dx) && (res_dy > ev_rdata.dy) &&
                    (res_dz > ev_rdata.dz) && (res_count > ev_rdata.count);

  // Next state and handshake
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (in_func == FUNC_SAMPLE && have_prev && fill_done) begin
            state_next = ST_SUM;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_SUM: begin
        if (sum_last) begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (cmp_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hand over once the result register is free or being drained
        if (!out_valid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_level <= '0;
      prev_sample <= '0;
      have_prev   <= 1'b0;
      wr_idx      <= '0;
      ring_full   <= 1'b0;
      ev_valid    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        noise_level <= cfg_data;
      end
      if (accept) begin
        case (in_func)
          FUNC_SAMPLE: begin
            prev_sample <= in_sample;
            have_prev   <= 1'b1;
            if (have_prev) begin
              ring_full <= fill_done;
              wr_idx    <= (wr_idx == RW'(WINDOW_LEN - 1)) ? '0 : wr_idx + 1'b1;
            end
          end
          FUNC_SET: begin
            if (slot_ok) begin
              ev_valid[in_slot[SW-1:0]] <= 1'b1;
            end
          end
          FUNC_CLEAR: begin
            if (slot_ok) begin
              ev_valid[in_slot[SW-1:0]] <= 1'b0;
            end
          end
          FUNC_NOP: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Delta ring: write on a sample with history, read during the window walk
  always_ff @(posedge clk) begin
    if (accept && in_func == FUNC_SAMPLE && have_prev) begin
      ring_mem[wr_idx] <= new_delta;
    end
    if (state == ST_SUM && cnt < IW'(WINDOW_LEN)) begin
      ring_rdata <= ring_mem[cnt[RW-1:0]];
    end
  end

  // Slot table: write on set, read during the slot walk
  always_ff @(posedge clk) begin
    if (accept && in_func == FUNC_SET && slot_ok) begin
      ev_mem[in_slot[SW-1:0]] <= in_base;
    end
    if (state == ST_CMP && cnt < IW'(EVENT_SLOTS)) begin
      ev_rdata <= ev_mem[cnt[SW-1:0]];
    end
  end

  // Walk counter and accumulators; memory read data is registered before it is accumulated
  always_ff @(posedge clk) begin
    if (accept) begin
      cnt       <= '0;
      res_mask  <= '0;
      res_dx    <= '0;
      res_dy    <= '0;
      res_dz    <= '0;
      res_count <= '0;
      res_eval  <= 1'b0;
    end else if (state == ST_SUM) begin
      cnt <= sum_last ? '0 : cnt + 1'b1;
      if (cnt != '0 && entry_noisy) begin
        res_dx    <= res_dx + SUM_W'(ring_rdata.dx);
        res_dy    <= res_dy + SUM_W'(ring_rdata.dy);
        res_dz    <= res_dz + SUM_W'(ring_rdata.dz);
        res_count <= res_count + 1'b1;
      end
    end else if (state == ST_CMP) begin
      cnt <= cnt + 1'b1;
      if (cnt != '0 && slot_hit) begin
        res_mask <= res_mask | (MASK_W'(1) << cnt_m1);
      end
      if (cmp_last) begin
        res_eval <= 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_mask  <= res_mask;
      out_dx    <= res_dx;
      out_dy    <= res_dy;
      out_dz    <= res_dz;
      out_count <= res_count;
      out_eval  <= res_eval;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_eval;
  assign m_tdata  = {7'b0, out_count, out_dz, out_dy, out_dx, out_mask};

endmodule

@@ rtl/core/wmed_checker.sv @@
module wmed_checker
  import wmed_pkg::*;
#(
  parameter int WINDOW_LEN  = 16,
  parameter int EVENT_SLOTS = 8
) (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tuser
);

  // A result waiting on the sink holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // A result without comparison carries all-zero fields
  a_zero_unevaluated: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("unevaluated result not zero");

  // Noisy count never exceeds the window, mask never names a missing slot
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[72:68] <= COUNT_W'(WINDOW_LEN) &&
                 (m_tdata[7:0] >> EVENT_SLOTS) == '0)
    else $error("count or mask out of range");

  // One request at a time: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("back-to-back accept");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind windowed_motion_event_detector wmed_checker #(
  .WINDOW_LEN  (WINDOW_LEN),
  .EVENT_SLOTS (EVENT_SLOTS)
) u_wmed_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ bench/windowed_motion_event_detector_tb.sv @@
module windowed_motion_event_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wmed_pkg::*;

  localparam int WINDOW_LEN  = 16;
  localparam int EVENT_SLOTS = 8;
  localparam int NOISE_MAX   = 196605;   // three full-scale deltas
  localparam int DRAIN_CYCLES = WINDOW_LEN + EVENT_SLOTS + 16;

  // One request on the input stream, field by field
  typedef struct {
    func_t                    func;
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
    logic [SLOT_W-1:0]        slot;
    logic [SUM_W-1:0]         bdx;
    logic [SUM_W-1:0]         bdy;
    logic [SUM_W-1:0]         bdz;
    logic [COUNT_W-1:0]       bcnt;
  } motion_req_t;

  // One result on the output stream
  typedef struct {
    logic [MASK_W-1:0]  mask;
    logic [SUM_W-1:0]   sx;
    logic [SUM_W-1:0]   sy;
    logic [SUM_W-1:0]   sz;
    logic [COUNT_W-1:0] cnt;
    logic               evaluated;
  } motion_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0]   s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [NOISE_W-1:0]  cfg_data = '0;

  windowed_motion_event_detector #(
    .WINDOW_LEN (WINDOW_LEN),
    .EVENT_SLOTS(EVENT_SLOTS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ------------------------------------------------------------------
  // Detector shadow state, advanced once per accepted request
  // ------------------------------------------------------------------
  int unsigned                noise_thr;
  logic signed [AXIS_W-1:0]   prev_x, prev_y, prev_z;
  bit                         have_prev;
  logic [DELTA_W-1:0]         ring_dx [WINDOW_LEN];
  logic [DELTA_W-1:0]         ring_dy [WINDOW_LEN];
  logic [DELTA_W-1:0]         ring_dz [WINDOW_LEN];
  int unsigned                write_pos;
  bit                         ring_filled;
  int unsigned                slot_bx [EVENT_SLOTS];
  int unsigned                slot_by [EVENT_SLOTS];
  int unsigned                slot_bz [EVENT_SLOTS];
  int unsigned                slot_bc [EVENT_SLOTS];
  logic [EVENT_SLOTS-1:0]     slot_armed;

  // Most recent window sums; baselines are drawn near them so slots fire
  int unsigned last_sx, last_sy, last_sz, last_cnt;

  // Previous generated sample, for smooth motion
  int stim_x, stim_y, stim_z;

  motion_result_t expected_results[$];
  int             mismatch_count;

  bit src_idle_on;
  bit sink_idle_on;
  int sink_hold_cycles;

  function automatic logic [DELTA_W-1:0] abs_delta(logic signed [AXIS_W-1:0] a,
                                                  logic signed [AXIS_W-1:0] b);
    int d;
    d = int'(a) - int'(b);
    return DELTA_W'((d < 0) ? -d : d);
  endfunction

  // Advance the shadow state by one request and return the result it causes
  function automatic motion_result_t predict_motion(motion_req_t r);
    motion_result_t res;
    int unsigned    sx, sy, sz, cnt, tot;
    res = '{mask: '0, sx: '0, sy: '0, sz: '0, cnt: '0, evaluated: 1'b0};
    sx = 0;
    sy = 0;
    sz = 0;
    cnt = 0;
    case (r.func)
      FUNC_SAMPLE: begin
        if (!have_prev) begin
          // first sample only seeds the history
          have_prev = 1'b1;
        end else begin
          ring_dx[write_pos] = abs_delta(r.ax, prev_x);
          ring_dy[write_pos] = abs_delta(r.ay, prev_y);
          ring_dz[write_pos] = abs_delta(r.az, prev_z);
          if (write_pos == WINDOW_LEN - 1) ring_filled = 1'b1;
          if (ring_filled) begin
            for (int i = 0; i < WINDOW_LEN; i++) begin
              tot = ring_dx[i] + ring_dy[i] + ring_dz[i];
              if (tot > noise_thr) begin
                sx += ring_dx[i];
                sy += ring_dy[i];
                sz += ring_dz[i];
                cnt++;
              end
            end
            for (int s = 0; s < EVENT_SLOTS; s++) begin
              if (slot_armed[s] && sx > slot_bx[s] && sy > slot_by[s] &&
                  sz > slot_bz[s] && cnt > slot_bc[s])
                res.mask[s] = 1'b1;
            end
            res.sx = SUM_W'(sx);
            res.sy = SUM_W'(sy);
            res.sz = SUM_W'(sz);
            res.cnt = COUNT_W'(cnt);
            res.evaluated = 1'b1;
            last_sx = sx;
            last_sy = sy;
            last_sz = sz;
            last_cnt = cnt;
          end
          write_pos = (write_pos + 1) % WINDOW_LEN;
        end
        prev_x = r.ax;
        prev_y = r.ay;
        prev_z = r.az;
      end
      FUNC_SET: begin
        if (r.slot < EVENT_SLOTS) begin
          slot_bx[r.slot] = r.bdx;
          slot_by[r.slot] = r.bdy;
          slot_bz[r.slot] = r.bdz;
          // cap the count at the window length
          slot_bc[r.slot] = (r.bcnt > WINDOW_LEN) ? WINDOW_LEN : r.bcnt;
          slot_armed[r.slot] = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        if (r.slot < EVENT_SLOTS) slot_armed[r.slot] = 1'b0;
      end
      default: ;  // unknown function changes nothing
    endcase
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // Fill every field at random so unused fields toggle too
  function automatic motion_req_t random_request();
    motion_req_t r;
    r.func = FUNC_SAMPLE;
    r.ax   = AXIS_W'($urandom());
    r.ay   = AXIS_W'($urandom());
    r.az   = AXIS_W'($urandom());
    r.slot = SLOT_W'($urandom_range(0, EVENT_SLOTS - 1));
    r.bdx  = SUM_W'($urandom());
    r.bdy  = SUM_W'($urandom());
    r.bdz  = SUM_W'($urandom());
    r.bcnt = COUNT_W'($urandom());
    return r;
  endfunction

  function automatic int step_axis(int v, int spread);
    int n;
    n = v + int'($urandom_range(0, 2 * spread)) - spread;
    if (n > 32767) n = 32767;
    if (n < -32768) n = -32768;
    return n;
  endfunction

  // Pick a sample: gentle jitter, larger swings, full-range noise or rail hits
  function automatic motion_req_t make_sample();
    motion_req_t r;
    int          mode, spread;
    r = random_request();
    mode = $urandom_range(0, 9);
    if (mode < 7) begin
      spread = (mode < 4) ? 40 : 3000;
      stim_x = step_axis(stim_x, spread);
      stim_y = step_axis(stim_y, spread);
      stim_z = step_axis(stim_z, spread);
    end else if (mode < 9) begin
      stim_x = int'(r.ax);
      stim_y = int'(r.ay);
      stim_z = int'(r.az);
    end else begin
      stim_x = $urandom_range(0, 1) ? 32767 : -32768;
      stim_y = $urandom_range(0, 1) ? 32767 : -32768;
      stim_z = $urandom_range(0, 1) ? 32767 : -32768;
    end
    r.ax = AXIS_W'(stim_x);
    r.ay = AXIS_W'(stim_y);
    r.az = AXIS_W'(stim_z);
    return r;
  endfunction

  function automatic int unsigned near_value(int unsigned v);
    int unsigned k;
    k = $urandom_range(0, v / 4 + 1);
    return (k > v) ? 0 : v - k;
  endfunction

  // Baselines half the time just under the live sums, so a fair share of slots fire
  function automatic motion_req_t make_baseline();
    motion_req_t r;
    int          mode;
    r = random_request();
    r.func = FUNC_SET;
    mode = $urandom_range(0, 3);
    if (mode < 2) begin
      r.bdx  = SUM_W'(near_value(last_sx));
      r.bdy  = SUM_W'(near_value(last_sy));
      r.bdz  = SUM_W'(near_value(last_sz));
      r.bcnt = COUNT_W'((last_cnt < 2) ? 0 : last_cnt - $urandom_range(0, 2));
    end else if (mode == 3) begin
      r.bdx  = SUM_W'($urandom_range(0, 255));
      r.bdy  = SUM_W'($urandom_range(0, 255));
      r.bdz  = SUM_W'($urandom_range(0, 255));
      r.bcnt = COUNT_W'($urandom_range(0, 3));
    end
    return r;
  endfunction

  // Offer one request, with an optional gap first, and hold it until taken
  task automatic send_request(input motion_req_t r);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, r.bcnt, r.bdz, r.bdy, r.bdx, r.slot, r.az, r.ay, r.ax};
    s_tuser  <= r.func;
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_motion(r));
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic wait_for_quiet();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_noise_level(input int unsigned level);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= NOISE_W'(level);
    do @(posedge clk); while (!cfg_ready);
    noise_thr = level;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_traffic(input int count);
    motion_req_t r;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        r = make_sample();
      end else if (pick < 84) begin
        r = make_baseline();
      end else if (pick < 95) begin
        r = random_request();
        r.func = FUNC_CLEAR;
      end else begin
        r = random_request();
        r.func = FUNC_NOP;
      end
      send_request(r);
    end
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Corner cases at the reset noise level of zero: no-op request, clear of a
  // free slot, oversized count, overwrite of a used slot, warm-up samples and
  // full-scale swings between the rails.
  task automatic test_directed_corners();
    motion_req_t r;
    bit          hi;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;

    r = random_request();
    r.func = FUNC_NOP;
    r.ax = '1; r.ay = '1; r.az = '1; r.slot = '1;
    r.bdx = '1; r.bdy = '1; r.bdz = '1; r.bcnt = '1;
    send_request(r);

    r = random_request();
    r.func = FUNC_CLEAR;
    r.slot = 5;
    send_request(r);

    r = random_request();
    r.func = FUNC_SET;
    r.slot = 0; r.bdx = '0; r.bdy = '0; r.bdz = '0; r.bcnt = '0;
    send_request(r);

    r.slot = 7; r.bdx = '1; r.bdy = '1; r.bdz = '1; r.bcnt = 31;
    send_request(r);

    r.slot = 3; r.bdx = 100; r.bdy = 100; r.bdz = 100; r.bcnt = 17;
    send_request(r);

    // overwrite slot 3 with higher sums and a lower count
    r.slot = 3; r.bdx = 1000; r.bdy = 1000; r.bdz = 1000; r.bcnt = 5;
    send_request(r);

    // seed the history, then swing rail to rail; one repeat leaves a quiet entry
    r = random_request();
    r.ax = -32768; r.ay = 32767; r.az = -32768;
    send_request(r);
    hi = 1'b1;
    for (int j = 0; j < WINDOW_LEN; j++) begin
      r = random_request();
      if (j != 5) hi = ~hi;
      r.ax = hi ? -32768 : 32767;
      r.ay = hi ? 32767 : -32768;
      r.az = hi ? -32768 : 32767;
      send_request(r);
    end

    r = random_request();
    r.func = FUNC_CLEAR;
    r.slot = 0;
    send_request(r);

    r = random_request();
    r.ax = '0; r.ay = '0; r.az = '0;
    send_request(r);

    wait_for_quiet();
  endtask

  // Noise level at both ends: nothing counts at the top, everything non-zero
  // counts at the bottom.
  task automatic test_noise_extremes();
    write_noise_level(NOISE_MAX);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    run_random_traffic(60);
    wait_for_quiet();

    write_noise_level(0);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    run_random_traffic(60);
    wait_for_quiet();
  endtask

  // Hold the output off for a long stretch while requests keep coming, so the
  // result register fills and the input stalls.
  task automatic test_output_backpressure();
    motion_req_t r;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    sink_hold_cycles = 400;
    for (int n = 0; n < 10; n++) begin
      r = make_sample();
      send_request(r);
    end
    wait_for_quiet();
  endtask

  // Several random noise levels, with idling switched on and off per phase
  task automatic test_noise_sweep();
    int unsigned level;
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: level = $urandom_range(0, 200);
        1: level = $urandom_range(0, 6000);
        2: level = $urandom_range(131072, NOISE_MAX);
        default: level = $urandom_range(0, NOISE_MAX);
      endcase
      write_noise_level(level);
      src_idle_on  = (p % 2 == 0);
      sink_idle_on = (p != 3);
      run_random_traffic(60);
      wait_for_quiet();
    end
  endtask

  // ------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------

  // Accept results, stalling a random number of cycles before each one when sink
  // idling is on, or for a long requested stretch.
  initial begin : result_sink
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (sink_hold_cycles > 0) begin
        stall = sink_hold_cycles;
        sink_hold_cycles = 0;
      end else begin
        stall = sink_idle_on ? $urandom_range(0, 12) : 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each accepted result against the oldest outstanding prediction
  always @(posedge clk) begin : result_check
    motion_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: tdata %0h tuser %0b", m_tdata, m_tuser);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("trigger_mask", want.mask, m_tdata[7:0]);
        check_field("sum_dx", want.sx, m_tdata[27:8]);
        check_field("sum_dy", want.sy, m_tdata[47:28]);
        check_field("sum_dz", want.sz, m_tdata[67:48]);
        check_field("noisy_count", want.cnt, m_tdata[72:68]);
        check_field("evaluated", want.evaluated, m_tuser);
      end
    end
  end

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin
    noise_thr        = 0;
    prev_x           = '0;
    prev_y           = '0;
    prev_z           = '0;
    have_prev        = 1'b0;
    write_pos        = 0;
    ring_filled      = 1'b0;
    slot_armed       = '0;
    last_sx          = 0;
    last_sy          = 0;
    last_sz          = 0;
    last_cnt         = 0;
    stim_x           = 0;
    stim_y           = 0;
    stim_z           = 0;
    mismatch_count   = 0;
    src_idle_on      = 1'b0;
    sink_idle_on     = 1'b0;
    sink_hold_cycles = 0;

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_noise_extremes();
    test_output_backpressure();
    test_noise_sweep();

    wait_for_quiet();
    // let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
